// ----- hdl/ehd_pkg.sv -----
package ehd_pkg;

   typedef enum logic [3:0] {
      KIND_TIMESTAMP    = 4'd0,
      KIND_CFD          = 4'd1,
      KIND_ENERGY       = 4'd2,
      KIND_TRAILING_SUM = 4'd3,
      KIND_LEADING_SUM  = 4'd4,
      KIND_GAP_SUM      = 4'd5,
      KIND_QDC          = 4'd6,
      KIND_SAMPLE       = 4'd7,
      KIND_ERROR        = 4'd8
   } kind_type;

   typedef struct packed {
      logic        esum;
      logic        qdc;
      logic        trace;
      logic [15:0] length;
   } layout_type;

   typedef struct packed {
      kind_type    kind;
      logic [47:0] value;
      logic [15:0] index;
   } result_type;

   localparam int          LAYOUT_WIDTH = $bits(layout_type);
   localparam int          MAX_RESULTS  = 4;
   localparam int          CANDIDATES   = 8;
   localparam logic [15:0] MAX_TRACE    = 16'd8192;
   localparam logic [15:0] POSITION_MAX = 16'hffff;

endpackage

// ----- hdl/ehd_ram.sv -----
module ehd_ram #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/digitizer_event_header_decoder.sv -----
// Decoder for list-mode digitizer event words.
// The req_ channel carries two kinds of transaction. With req_mode low it writes
// the layout entry of one slot and channel; with req_mode high it presents one
// 32-bit event word, and req_first_word marks the word that opens an event.
// The rsp_ channel returns decoded fields one per transaction: kind, value,
// index, and rsp_last on the final result that one event word caused.
// A word yields zero to four results. Layout entries live in a synchronous RAM;
// a word enters, reads the table if it opens an event, and is decoded in the
// following cycle from the input stage register; its results then pass through
// the output register before they appear on the rsp_ port.
// A new word is accepted every cycle while rsp_stall is low and it and its
// predecessor give at most one result each; a word with n results occupies the
// output register until all n have been taken, one per rsp_ transaction.
// When rsp_stall is high the held result stays on the port, one more word may
// sit decoded in the pipeline, and only then does req_stall rise.
// Reset is synchronous and marks every layout entry as unconfigured; it also
// drops any event in progress and any pending result.
module digitizer_event_header_decoder #(
   parameter int SLOTS    = 16,
   parameter int CHANNELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [3:0]  req_layout_slot,
   input  logic [3:0]  req_layout_channel,
   input  logic        req_trace_enable,
   input  logic        req_qdc_enable,
   input  logic        req_energy_sums_enable,
   input  logic [15:0] req_trace_length,
   input  logic [31:0] req_event_word,
   input  logic        req_first_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [47:0] rsp_value,
   output logic [15:0] rsp_index,
   output logic        rsp_last
);

   localparam int ENTRIES = SLOTS * CHANNELS;
   localparam int AW      = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

   logic                  req_accept;
   logic [7:0]            lay_full_addr;
   logic [7:0]            ev_full_addr;
   logic                  lay_in_range;
   logic                  ev_in_range;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   ehd_pkg::layout_type   ram_wr_data;
   logic [ehd_pkg::LAYOUT_WIDTH-1:0] ram_rd_bits;
   ehd_pkg::layout_type   ram_rd_data;

   logic [ENTRIES-1:0]    entry_valid_ff, entry_valid_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_mode_ff;
   logic                  s1_first_ff;
   logic                  s1_hit_ff;
   logic [31:0]           s1_word_ff;

   logic                  active_ff, active_in;
   ehd_pkg::layout_type   cur_layout_ff, cur_layout_in;
   logic [15:0]           position_ff, position_in;
   logic [4:0]            header_len_ff, header_len_in;
   logic [31:0]           ts_low_ff, ts_low_in;

   ehd_pkg::layout_type   lay;
   logic                  start;
   logic                  proceed;
   logic [15:0]           p;
   logic [4:0]            hlen;
   logic                  trace_ok;
   logic                  trace_error;
   logic [15:0]           q0;
   logic [15:0]           trace_word;
   logic [16:0]           k2;
   logic [16:0]           k2_odd;
   ehd_pkg::result_type   cand [ehd_pkg::CANDIDATES];
   logic [ehd_pkg::CANDIDATES-1:0] cand_valid;
   ehd_pkg::result_type   list [ehd_pkg::MAX_RESULTS];
   logic [2:0]            list_cnt;

   logic                  s1_go;
   logic                  emit_free;
   logic                  rsp_take;
   logic                  emit_valid_ff, emit_valid_in;
   logic [2:0]            emit_cnt_ff, emit_cnt_in;
   logic [1:0]            emit_pos_ff, emit_pos_in;
   ehd_pkg::result_type   emit_res_ff [ehd_pkg::MAX_RESULTS];
   ehd_pkg::result_type   emit_res_in [ehd_pkg::MAX_RESULTS];
   ehd_pkg::result_type   emit_cur;

   assign req_accept    = req_valid && !req_stall;
   assign lay_full_addr = 8'(req_layout_slot) * 8'(CHANNELS) + 8'(req_layout_channel);
   assign ev_full_addr  = 8'(req_event_word[7:4]) * 8'(CHANNELS) + 8'(req_event_word[3:0]);
   assign lay_in_range  = (32'(req_layout_slot) < SLOTS) && (32'(req_layout_channel) < CHANNELS);
   assign ev_in_range   = (32'(req_event_word[7:4]) < SLOTS) &&
                          (32'(req_event_word[3:0]) < CHANNELS);

   assign ram_wr_en = req_accept && !req_mode && lay_in_range;
   assign ram_rd_en = req_accept && req_mode && req_first_word;

   always_comb begin
      ram_wr_data        = '0;
      ram_wr_data.esum   = req_energy_sums_enable;
      ram_wr_data.qdc    = req_qdc_enable;
      ram_wr_data.trace  = req_trace_enable;
      ram_wr_data.length = req_trace_enable ? req_trace_length : 16'd0;
   end

   ehd_ram #(
      .WIDTH (ehd_pkg::LAYOUT_WIDTH),
      .DEPTH (ENTRIES)
   ) u_layout_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (lay_full_addr[AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ev_full_addr[AW-1:0]),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = ehd_pkg::layout_type'(ram_rd_bits);

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (ram_wr_en) begin
         entry_valid_in[lay_full_addr[AW-1:0]] = 1'b1;
      end
   end

   // Stage 1: the accepted transaction, with the table read result registered alongside it.
   always_comb begin
      lay         = s1_first_ff ? ram_rd_data : cur_layout_ff;
      start       = s1_mode_ff && s1_first_ff && s1_hit_ff;
      proceed     = start || (s1_mode_ff && !s1_first_ff && active_ff &&
                              position_ff != ehd_pkg::POSITION_MAX);
      p           = s1_first_ff ? 16'd0 : position_ff + 16'd1;
      hlen        = s1_first_ff ? s1_word_ff[16:12] : header_len_ff;
      trace_ok    = lay.length != 16'd0 && lay.length < ehd_pkg::MAX_TRACE;
      trace_error = start && lay.length != 16'd0 && !(lay.length < ehd_pkg::MAX_TRACE);
      q0          = lay.esum ? 16'd8 : 16'd4;
      trace_word  = p - 16'(hlen);
      k2          = {trace_word, 1'b0};
      k2_odd      = {trace_word, 1'b1};

      for (int i = 0; i < ehd_pkg::CANDIDATES; i++) begin
         cand[i] = '0;
      end
      cand_valid = '0;

      cand[0].kind  = ehd_pkg::KIND_ERROR;
      cand_valid[0] = trace_error;

      cand[1].kind  = ehd_pkg::KIND_TIMESTAMP;
      cand[1].value = {s1_word_ff[15:0], ts_low_ff};
      cand_valid[1] = proceed && p == 16'd2;

      cand[2].kind  = ehd_pkg::KIND_CFD;
      cand[2].value = 48'(s1_word_ff[31:16]);
      cand_valid[2] = proceed && p == 16'd2;

      cand[3].kind  = ehd_pkg::KIND_ENERGY;
      cand[3].value = 48'(s1_word_ff[15:0]);
      cand_valid[3] = proceed && p == 16'd3;

      priority if (p == 16'd4) begin
         cand[4].kind = ehd_pkg::KIND_TRAILING_SUM;
      end else if (p == 16'd5) begin
         cand[4].kind = ehd_pkg::KIND_LEADING_SUM;
      end else begin
         cand[4].kind = ehd_pkg::KIND_GAP_SUM;
      end
      cand[4].value = 48'(s1_word_ff);
      cand_valid[4] = proceed && lay.esum && p >= 16'd4 && p <= 16'd6;

      cand[5].kind  = ehd_pkg::KIND_QDC;
      cand[5].value = 48'(s1_word_ff);
      cand[5].index = p - q0;
      cand_valid[5] = proceed && lay.qdc && p >= q0 && p < q0 + 16'd8;

      cand[6].kind  = ehd_pkg::KIND_SAMPLE;
      cand[6].value = 48'(s1_word_ff[13:0]);
      cand[6].index = k2[15:0];
      cand_valid[6] = proceed && trace_ok && p >= 16'(hlen) && k2 < 17'(lay.length);

      cand[7].kind  = ehd_pkg::KIND_SAMPLE;
      cand[7].value = 48'(s1_word_ff[29:16]);
      cand[7].index = k2_odd[15:0];
      cand_valid[7] = proceed && trace_ok && p >= 16'(hlen) && k2_odd < 17'(lay.length);
   end

   always_comb begin
      for (int i = 0; i < ehd_pkg::MAX_RESULTS; i++) begin
         list[i] = '0;
      end
      list_cnt = 3'd0;
      for (int i = 0; i < ehd_pkg::CANDIDATES; i++) begin
         if (cand_valid[i] && list_cnt < 3'(ehd_pkg::MAX_RESULTS)) begin
            list[list_cnt[1:0]] = cand[i];
            list_cnt            = list_cnt + 3'd1;
         end
      end
   end

   assign emit_cur  = emit_res_ff[emit_pos_ff];
   assign rsp_valid = emit_valid_ff;
   assign rsp_kind  = emit_cur.kind;
   assign rsp_value = emit_cur.value;
   assign rsp_index = emit_cur.index;
   assign rsp_last  = 3'(emit_pos_ff) + 3'd1 == emit_cnt_ff;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign emit_free = !emit_valid_ff || (rsp_take && rsp_last);
   assign s1_go     = s1_valid_ff && (list_cnt == 3'd0 || emit_free);
   assign req_stall = s1_valid_ff && !s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      active_in     = active_ff;
      cur_layout_in = cur_layout_ff;
      position_in   = position_ff;
      header_len_in = header_len_ff;
      ts_low_in     = ts_low_ff;
      if (s1_go && s1_mode_ff) begin
         if (s1_first_ff) begin
            active_in = s1_hit_ff;
            if (s1_hit_ff) begin
               cur_layout_in = ram_rd_data;
               position_in   = 16'd0;
               header_len_in = s1_word_ff[16:12];
            end
         end else if (proceed) begin
            position_in = p;
            if (p == 16'd1) begin
               ts_low_in = s1_word_ff;
            end
         end
      end
   end

   always_comb begin
      emit_valid_in = emit_valid_ff;
      emit_cnt_in   = emit_cnt_ff;
      emit_pos_in   = emit_pos_ff;
      emit_res_in   = emit_res_ff;
      if (s1_go && list_cnt != 3'd0) begin
         emit_valid_in = 1'b1;
         emit_cnt_in   = list_cnt;
         emit_pos_in   = 2'd0;
         emit_res_in   = list;
      end else if (rsp_take) begin
         if (rsp_last) begin
            emit_valid_in = 1'b0;
         end else begin
            emit_pos_in = emit_pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         s1_valid_ff    <= 1'b0;
         active_ff      <= 1'b0;
         cur_layout_ff  <= '0;
         position_ff    <= 16'd0;
         header_len_ff  <= 5'd0;
         ts_low_ff      <= 32'd0;
         emit_valid_ff  <= 1'b0;
         emit_cnt_ff    <= 3'd0;
         emit_pos_ff    <= 2'd0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         s1_valid_ff    <= s1_valid_in;
         active_ff      <= active_in;
         cur_layout_ff  <= cur_layout_in;
         position_ff    <= position_in;
         header_len_ff  <= header_len_in;
         ts_low_ff      <= ts_low_in;
         emit_valid_ff  <= emit_valid_in;
         emit_cnt_ff    <= emit_cnt_in;
         emit_pos_ff    <= emit_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff  <= req_mode;
         s1_first_ff <= req_first_word;
         s1_word_ff  <= req_event_word;
         s1_hit_ff   <= ev_in_range && entry_valid_ff[ev_full_addr[AW-1:0]];
      end
      emit_res_ff <= emit_res_in;
   end

endmodule

// ----- hdl/ehd_checker.sv -----
module ehd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_kind,
   input logic [47:0] rsp_value,
   input logic [15:0] rsp_index,
   input logic        rsp_last
);

   // A result that waits on the receiver stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value) &&
                                 $stable(rsp_index) && $stable(rsp_last))
      else $error("stalled result changed");

   // A trace error comes only from an opening word that gives no other result, so it is last and zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ehd_pkg::KIND_ERROR |-> rsp_last && rsp_value == 48'd0)
      else $error("error result is not alone");

   // The timestamp is always followed by the CFD of the same word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ehd_pkg::KIND_TIMESTAMP |-> !rsp_last)
      else $error("timestamp marked last");

   // Reset drops every pending result and empties the input stage.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // The input stage holds only while it cannot hand its word on.
   assert property (@(posedge clock) disable iff (reset)
      req_stall && !req_valid |-> rsp_valid)
      else $error("input stalled without a pending result");

endmodule

bind digitizer_event_header_decoder ehd_checker u_ehd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_kind  (rsp_kind),
   .rsp_value (rsp_value),
   .rsp_index (rsp_index),
   .rsp_last  (rsp_last)
);

// ----- sim/event_decoder_checker.sv -----
module event_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_mode,
   input  logic [3:0]  req_layout_slot,
   input  logic [3:0]  req_layout_channel,
   input  logic        req_trace_enable,
   input  logic        req_qdc_enable,
   input  logic        req_energy_sums_enable,
   input  logic [15:0] req_trace_length,
   input  logic [31:0] req_event_word,
   input  logic        req_first_word,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_kind,
   input  logic [47:0] rsp_value,
   input  logic [15:0] rsp_index,
   input  logic        rsp_last,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      ehd_pkg::kind_type kind;
      logic [47:0]       value;
      logic [15:0]       index;
      logic              last;
   } decoded_field_type;

   ehd_pkg::layout_type layouts [256];
   bit                  layout_written [256];
   ehd_pkg::layout_type event_layout;
   logic [15:0]         word_position;
   logic [4:0]          header_length;
   logic [31:0]         timestamp_low;
   bit                  event_open;
   decoded_field_type   staged [ehd_pkg::MAX_RESULTS];
   int                  staged_count;
   decoded_field_type   awaited_fields [$];
   int                  mismatch_count;

   function automatic void stage_field(ehd_pkg::kind_type kind, logic [47:0] value,
                                       logic [15:0] index);
      if (staged_count < ehd_pkg::MAX_RESULTS) begin
         staged[staged_count] = '{kind, value, index, 1'b0};
         staged_count++;
      end
   endfunction

   function automatic void clear_model();
      for (int i = 0; i < 256; i++) begin
         layouts[i] = '0;
         layout_written[i] = 1'b0;
      end
      event_layout = '0;
      word_position = '0;
      header_length = '0;
      timestamp_low = '0;
      event_open = 1'b0;
      awaited_fields.delete();
   endfunction

   function automatic void decode_event_word();
      int          p;
      int          len;
      int          q0;
      int          pair;
      logic [31:0] w;
      logic [7:0]  entry;
      w = req_event_word;
      staged_count = 0;
      if (!req_mode) begin
         entry = {req_layout_slot, req_layout_channel};
         layouts[entry] = '{esum: req_energy_sums_enable, qdc: req_qdc_enable,
                            trace: req_trace_enable,
                            length: req_trace_enable ? req_trace_length : 16'd0};
         layout_written[entry] = 1'b1;
         return;
      end
      if (req_first_word) begin
         entry = w[7:0];
         event_open = 1'b0;
         if (!layout_written[entry])
            return;
         event_open = 1'b1;
         event_layout = layouts[entry];
         word_position = '0;
         header_length = w[16:12];
         if (event_layout.length != 0 && event_layout.length >= ehd_pkg::MAX_TRACE)
            stage_field(ehd_pkg::KIND_ERROR, '0, '0);
      end else begin
         if (!event_open || word_position == ehd_pkg::POSITION_MAX)
            return;
         word_position++;
      end
      p = word_position;
      len = event_layout.length;
      q0 = event_layout.esum ? 8 : 4;
      case (p)
         1: timestamp_low = w;
         2: begin
            stage_field(ehd_pkg::KIND_TIMESTAMP, {w[15:0], timestamp_low}, '0);
            stage_field(ehd_pkg::KIND_CFD, 48'(w[31:16]), '0);
         end
         3: stage_field(ehd_pkg::KIND_ENERGY, 48'(w[15:0]), '0);
         4: if (event_layout.esum) stage_field(ehd_pkg::KIND_TRAILING_SUM, 48'(w), '0);
         5: if (event_layout.esum) stage_field(ehd_pkg::KIND_LEADING_SUM, 48'(w), '0);
         6: if (event_layout.esum) stage_field(ehd_pkg::KIND_GAP_SUM, 48'(w), '0);
         default: ;
      endcase
      if (event_layout.qdc && p >= q0 && p < q0 + 8)
         stage_field(ehd_pkg::KIND_QDC, 48'(w), 16'(p - q0));
      if (len != 0 && len < int'(ehd_pkg::MAX_TRACE) && p >= int'(header_length)) begin
         pair = (p - int'(header_length)) * 2;
         if (pair < len)
            stage_field(ehd_pkg::KIND_SAMPLE, 48'(w[13:0]), 16'(pair));
         if (pair + 1 < len)
            stage_field(ehd_pkg::KIND_SAMPLE, 48'(w[29:16]), 16'(pair + 1));
      end
      for (int i = 0; i < staged_count; i++) begin
         if (i == staged_count - 1)
            staged[i].last = 1'b1;
         awaited_fields.push_back(staged[i]);
      end
   endfunction

   function automatic void check_result();
      decoded_field_type want;
      if (awaited_fields.size() == 0) begin
         $error("unexpected result: kind %0d, value %0h, index %0d",
                rsp_kind, rsp_value, rsp_index);
         mismatch_count++;
         return;
      end
      want = awaited_fields.pop_front();
      if (rsp_kind !== want.kind) begin
         $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
         mismatch_count++;
      end
      if (rsp_value !== want.value) begin
         $error("value: expected %0h, got %0h", want.value, rsp_value);
         mismatch_count++;
      end
      if (rsp_index !== want.index) begin
         $error("index: expected %0d, got %0d", want.index, rsp_index);
         mismatch_count++;
      end
      if (rsp_last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, rsp_last);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            decode_event_word();
      end
      failures <= mismatch_count;
      pending <= awaited_fields.size();
   end

endmodule

// ----- sim/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_mode;
   logic [3:0]  req_layout_slot;
   logic [3:0]  req_layout_channel;
   logic        req_trace_enable;
   logic        req_qdc_enable;
   logic        req_energy_sums_enable;
   logic [15:0] req_trace_length;
   logic [31:0] req_event_word;
   logic        req_first_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_kind;
   logic [47:0] rsp_value;
   logic [15:0] rsp_index;
   logic        rsp_last;
   int          failures;
   int          pending;

   bit          calm;
   int          counted;
   bit          known [256];
   int          sample_words [256];
   logic [7:0]  known_entries [$];

   digitizer_event_header_decoder uut (.*);

   event_decoder_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   task automatic send_item(input logic mode, input logic [3:0] slot, input logic [3:0] channel,
                            input logic trace_on, input logic qdc_en, input logic esum_en,
                            input logic [15:0] trace_len, input logic [31:0] word,
                            input logic first);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_layout_slot <= slot;
      req_layout_channel <= channel;
      req_trace_enable <= trace_on;
      req_qdc_enable <= qdc_en;
      req_energy_sums_enable <= esum_en;
      req_trace_length <= trace_len;
      req_event_word <= word;
      req_first_word <= first;
      do @(posedge clock); while (req_stall);
      counted++;
   endtask

   task automatic write_layout(input logic [3:0] slot, input logic [3:0] channel,
                               input logic trace_on, input logic qdc_en, input logic esum_en,
                               input logic [15:0] trace_len);
      logic [7:0] entry;
      entry = {slot, channel};
      send_item(1'b0, slot, channel, trace_on, qdc_en, esum_en, trace_len, $urandom,
                1'($urandom));
      if (!known[entry])
         known_entries.push_back(entry);
      known[entry] = 1'b1;
      sample_words[entry] = (trace_on && trace_len != 0 && trace_len < ehd_pkg::MAX_TRACE) ?
                            (int'(trace_len) + 1) / 2 : 0;
   endtask

   task automatic send_word(input logic [31:0] word, input logic first);
      send_item(1'b1, 4'($urandom), 4'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                16'($urandom), word, first);
   endtask

   task automatic run_event(input logic [7:0] entry, input logic [4:0] hdr_len, input int words);
      logic [31:0] head;
      head = $urandom;
      head[7:0] = entry;
      head[16:12] = hdr_len;
      send_word(head, 1'b1);
      repeat (words) send_word($urandom, 1'b0);
   endtask

   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 7);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      logic [7:0]  entry;
      logic [4:0]  hdr_len;
      logic [15:0] trace_len;
      int          words;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_layout_slot = '0;
      req_layout_channel = '0;
      req_trace_enable = 1'b0;
      req_qdc_enable = 1'b0;
      req_energy_sums_enable = 1'b0;
      req_trace_length = '0;
      req_event_word = '0;
      req_first_word = 1'b0;
      calm = 1'b0;
      counted = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Full header with sums and QDC words, overlapped by a short trace.
      write_layout(4'hf, 4'hf, 1'b1, 1'b1, 1'b1, 16'd5);
      send_word(32'hfffe_cfff, 1'b1);
      for (int i = 1; i <= 15; i++)
         send_word((i % 4 == 3) ? 32'h0000_0000 : 32'hffff_ffff, 1'b0);

      write_layout(4'h0, 4'h0, 1'b1, 1'b0, 1'b0, ehd_pkg::MAX_TRACE);
      send_word(32'h0000_0000, 1'b1);
      send_word(32'h0000_0037, 1'b1);
      send_word($urandom, 1'b0);

      write_layout(4'h1, 4'h2, 1'b1, 1'b1, 1'b0, 16'd12);
      run_event(8'h12, 5'd0, 4);

      // A long header without a trace gives only header fields.
      write_layout(4'h2, 4'h3, 1'b0, 1'b1, 1'b1, 16'hffff);
      calm = 1'b1;
      run_event(8'h23, 5'd31, 20);
      calm = 1'b0;

      while (counted < 230) begin
         calm = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0, 1: begin
               if ($urandom_range(0, 2) == 0)
                  entry = known_entries[$urandom_range(0, known_entries.size() - 1)];
               else
                  entry = 8'($urandom);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: trace_len = 16'($urandom_range(0, 12));
                  6:                trace_len = 16'($urandom_range(8190, 8193));
                  7:                trace_len = $urandom_range(0, 1) ? 16'hffff : 16'd0;
                  default:          trace_len = 16'($urandom_range(13, 48));
               endcase
               write_layout(entry[7:4], entry[3:0], $urandom_range(0, 3) != 0, 1'($urandom),
                            1'($urandom), trace_len);
            end
            2: send_word($urandom, 1'($urandom));
            default: begin
               if ($urandom_range(0, 9) != 0)
                  entry = known_entries[$urandom_range(0, known_entries.size() - 1)];
               else
                  entry = 8'($urandom);
               hdr_len = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16));
               words = int'(hdr_len) + ((sample_words[entry] > 24) ? 24 : sample_words[entry])
                       + $urandom_range(0, 3);
               if ($urandom_range(0, 6) == 0)
                  words = $urandom_range(0, words);
               run_event(entry, hdr_len, words);
            end
         endcase
      end

      calm = 1'b0;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (16) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
